// ===== hdl/epd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types and constants for the escaped packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

    localparam int DEF_MAX_PAYLOAD = 512;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 10;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] FRAME_CHAR_RESET = 8'd16;
    localparam logic [BYTE_W-1:0] FRAME_TERM_RESET = 8'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CHAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TERM = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] dup_count;
    } epd_result_t;

endpackage : epd_pkg
`default_nettype wire

// ===== hdl/epd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epd_core
// Per-byte deframing state: header capture, escape handling, checksum and
// payload count. Produces at most one result per accepted transaction.
// ----------------------------------------------------------------------------
module epd_core #(
    parameter int MAX_PAYLOAD = epd_pkg::DEF_MAX_PAYLOAD
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [epd_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic                       resync,
    input  wire logic [epd_pkg::BYTE_W-1:0] frame_char,
    input  wire logic [epd_pkg::BYTE_W-1:0] frame_term,
    output epd_pkg::epd_result_t            result
);
    import epd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        PH_SUM  = 2'd0,
        PH_DUP  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] expected_reg, expected_next;
    logic [BYTE_W-1:0] dup_reg, dup_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              escape_reg, escape_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              is_data;

    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        dup_next      = dup_reg;
        sum_next      = sum_reg;
        escape_next   = escape_reg;
        count_next    = count_reg;
        is_data       = 1'b0;
        result        = '0;

        if (accept)
        begin
            if (resync)
            begin
                phase_next    = PH_SUM;
                expected_next = '0;
                dup_next      = '0;
                sum_next      = '0;
                escape_next   = 1'b0;
                count_next    = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SUM:
                    begin
                        expected_next = rx_byte;
                        sum_next      = '0;
                        phase_next    = PH_DUP;
                    end
                    PH_DUP:
                    begin
                        dup_next   = rx_byte;
                        phase_next = PH_BODY;
                    end
                    PH_BODY:
                    begin
                        // escapes and the terminator count towards the sum too
                        sum_next = sum_reg + rx_byte;
                        if (escape_reg)
                        begin
                            escape_next = 1'b0;
                            if (rx_byte == frame_term)
                            begin
                                result.valid     = 1'b1;
                                result.kind      = (sum_next == expected_reg) ?
                                                   KIND_GOOD : KIND_BAD;
                                result.position  = POS_W'(count_reg);
                                result.dup_count = dup_reg;
                                phase_next       = PH_SUM;
                                count_next       = '0;
                            end
                            else
                            begin
                                is_data = 1'b1;
                            end
                        end
                        else if (rx_byte == frame_char)
                        begin
                            escape_next = 1'b1;
                        end
                        else
                        begin
                            is_data = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SUM;
                    end
                endcase

                // oversize bytes are dropped silently
                if (is_data && (count_reg < CNT_MAX))
                begin
                    result.valid     = 1'b1;
                    result.kind      = KIND_BYTE;
                    result.data_byte = rx_byte;
                    result.position  = POS_W'(count_reg);
                    count_next       = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SUM;
            expected_reg <= '0;
            dup_reg      <= '0;
            sum_reg      <= '0;
            escape_reg   <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            dup_reg      <= dup_next;
            sum_reg      <= sum_next;
            escape_reg   <= escape_next;
            count_reg    <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_resync_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && resync |=> phase_reg == PH_SUM && count_reg == '0 && !escape_reg)
        else $error("resync did not clear deframer state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("payload count beyond limit");

    a_escape_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        escape_reg |-> phase_reg == PH_BODY)
        else $error("escape pending outside packet body");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != KIND_BYTE |=> phase_reg == PH_SUM && count_reg == '0)
        else $error("packet end did not return to header");
`endif

endmodule : epd_core
`default_nettype wire

// ===== hdl/escaped_packet_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_packet_deframer
// Deframes escaped serial bytes with an 8-bit additive checksum, emitting
// payload bytes with their index and a good/bad status at packet end.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   rx_byte, resync
//  out       output     out_valid / out_stall kind, data_byte, position, dup_count
//  cfg       input      cfg_write             cfg_index, cfg_data
//
//  one byte per cycle while in_stall is low; a result appears in the cycle after its transaction
//  the sole pipeline register is the result register; its state logic is a
//  single pass of compare and 8-bit add
//  in_stall rises only while a result is held and out_stall is high
//  rst_n is asynchronous and restores the header phase and default frame bytes
// ----------------------------------------------------------------------------
module escaped_packet_deframer #(
    parameter int MAX_PAYLOAD = epd_pkg::DEF_MAX_PAYLOAD
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [epd_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic                          resync,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [epd_pkg::KIND_W-1:0]         kind,
    output logic [epd_pkg::BYTE_W-1:0]         data_byte,
    output logic [epd_pkg::POS_W-1:0]          position,
    output logic [epd_pkg::BYTE_W-1:0]         dup_count,
    input  wire logic                          cfg_write,
    input  wire logic [epd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [epd_pkg::BYTE_W-1:0]    cfg_data
);
    import epd_pkg::*;

    logic [BYTE_W-1:0] frame_char_reg;
    logic [BYTE_W-1:0] frame_term_reg;
    logic              in_accept;
    epd_result_t       result;
    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [BYTE_W-1:0] dup_reg;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_char_reg <= FRAME_CHAR_RESET;
            frame_term_reg <= FRAME_TERM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_CHAR: frame_char_reg <= cfg_data;
                CFG_FRAME_TERM: frame_term_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    epd_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .rx_byte    (rx_byte),
        .resync     (resync),
        .frame_char (frame_char_reg),
        .frame_term (frame_term_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= result.valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && result.valid)
        begin
            kind_reg <= result.kind;
            data_reg <= result.data_byte;
            pos_reg  <= result.position;
            dup_reg  <= result.dup_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data_byte = data_reg;
    assign position  = pos_reg;
    assign dup_count = dup_reg;

`ifndef SYNTHESIS
    a_end_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> data_byte == '0)
        else $error("packet end transaction carries data");

    a_byte_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |-> dup_count == '0)
        else $error("payload transaction carries dup count");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_BYTE || kind == KIND_GOOD || kind == KIND_BAD)
        else $error("illegal result kind");
`endif

endmodule : escaped_packet_deframer
`default_nettype wire

// ===== tb/sv/escaped_packet_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_packet_deframer_tb
// Self-checking bench for the escaped packet deframer. Builds escaped packets
// with good and bad checksums, resyncs, oversize payloads and raw noise under
// several frame byte settings, predicts every payload byte and packet status
// in a cycle-free model, and compares each output transaction field by field
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module escaped_packet_deframer_tb;
    import epd_pkg::*;

    localparam int PAYLOAD_LIMIT = DEF_MAX_PAYLOAD;
    localparam int RANDOM_ITEMS  = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 50000;

    // indexes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum logic [1:0] {
        AWAIT_SUM,
        AWAIT_DUP,
        IN_BODY
    } rx_phase_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURSTY
    } stall_pattern_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] dup;
    } deframe_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 resync;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [POS_W-1:0]     position;
    logic [BYTE_W-1:0]    dup_count;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    // deframer model state
    rx_phase_t         rx_phase;
    logic [BYTE_W-1:0] hdr_sum;
    logic [BYTE_W-1:0] hdr_dup;
    logic [BYTE_W-1:0] body_sum;
    logic              esc_open;
    int                body_len;
    logic [BYTE_W-1:0] esc_char;
    logic [BYTE_W-1:0] term_char;
    deframe_out_t      expected_q[$];

    int unsigned item_count = 0;
    int          burst_left = 0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    int             hold_requests = 0;
    int             hold_served = 0;
    int             hold_left = 0;
    int             pattern_left = 0;
    stall_pattern_t stall_pattern = STALL_NONE;

    escaped_packet_deframer #(
        .MAX_PAYLOAD (PAYLOAD_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .resync    (resync),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .position  (position),
        .dup_count (dup_count),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void clear_rx_state();
        rx_phase = AWAIT_SUM;
        hdr_sum  = '0;
        hdr_dup  = '0;
        body_sum = '0;
        esc_open = 1'b0;
        body_len = 0;
    endfunction

    function automatic void predict_rx(input logic [BYTE_W-1:0] b, input logic rs);
        deframe_out_t r;
        if (rs)
            clear_rx_state();
        else if (rx_phase == AWAIT_SUM)
        begin
            hdr_sum  = b;
            body_sum = '0;
            rx_phase = AWAIT_DUP;
        end
        else if (rx_phase == AWAIT_DUP)
        begin
            hdr_dup  = b;
            rx_phase = IN_BODY;
        end
        else
        begin
            // escapes and the terminator count towards the sum too
            body_sum = body_sum + b;
            if (esc_open && b == term_char)
            begin
                r.kind = (body_sum == hdr_sum) ? KIND_GOOD : KIND_BAD;
                r.data = '0;
                r.pos  = body_len[POS_W-1:0];
                r.dup  = hdr_dup;
                expected_q.push_back(r);
                esc_open = 1'b0;
                rx_phase = AWAIT_SUM;
                body_len = 0;
            end
            else if (!esc_open && b == esc_char)
                esc_open = 1'b1;
            else
            begin
                esc_open = 1'b0;
                if (body_len < PAYLOAD_LIMIT)
                begin
                    r.kind = KIND_BYTE;
                    r.data = b;
                    r.pos  = body_len[POS_W-1:0];
                    r.dup  = '0;
                    expected_q.push_back(r);
                    body_len++;
                end
            end
        end
    endfunction

    // output checker: a transaction is taken at the next rising edge
    always @(negedge clk)
    begin
        deframe_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d data_byte %0h position %0d dup_count %0h",
                       kind, data_byte, position, dup_count);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    fail_count++;
                end
                if (data_byte !== want.data)
                begin
                    $error("data_byte: expected %0h, actual %0h", want.data, data_byte);
                    fail_count++;
                end
                if (position !== want.pos)
                begin
                    $error("position: expected %0d, actual %0d", want.pos, position);
                    fail_count++;
                end
                if (dup_count !== want.dup)
                begin
                    $error("dup_count: expected %0h, actual %0h", want.dup, dup_count);
                    fail_count++;
                end
            end
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                stall_pattern = stall_pattern_t'($urandom_range(0, 3));
                pattern_left  = $urandom_range(16, 96);
            end
            pattern_left--;
            case (stall_pattern)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((pattern_left % 5) < 2);
            endcase
        end
    end

    // sender: bursts of random length with random gaps in between
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic rs);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        resync   <= rs;
        do
            @(negedge clk);
        while (in_stall);
        predict_rx(b, rs);
        @(posedge clk);
        burst_left--;
        item_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // a byte with no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_FRAME_CHAR)
            esc_char = val;
        else if (idx == CFG_FRAME_TERM)
            term_char = val;
    endtask

    // one escaped packet under the current frame bytes, optionally cut by a resync
    task automatic send_packet(input int plen, input bit sum_ok, input bit cut);
        logic [BYTE_W-1:0] stream[$];
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] total;
        logic [BYTE_W-1:0] chk;
        int                cut_at;
        total = '0;
        for (int i = 0; i < plen; i++)
        begin
            case ($urandom_range(0, 7))
                0:       b = esc_char;
                1:       b = term_char;
                default: b = BYTE_W'($urandom_range(0, 255));
            endcase
            // with equal frame bytes that value cannot be carried as data
            if (esc_char == term_char && b == esc_char)
                b = b ^ 8'h01;
            if (b == esc_char || (b != term_char && $urandom_range(0, 15) == 0))
                stream.push_back(esc_char);
            stream.push_back(b);
        end
        stream.push_back(esc_char);
        stream.push_back(term_char);
        foreach (stream[i])
            total += stream[i];
        chk = sum_ok ? total : BYTE_W'(total + $urandom_range(1, 255));
        stream.push_front(BYTE_W'($urandom_range(0, 255)));
        stream.push_front(chk);
        cut_at = cut ? $urandom_range(0, stream.size() - 1) : -1;
        for (int i = 0; i < stream.size(); i++)
        begin
            if (i == cut_at)
            begin
                send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
                break;
            end
            send_item(stream[i], 1'b0);
        end
    endtask

    task automatic test_directed();
        logic [BYTE_W-1:0] chk;
        // data extremes, escaped frame char, escaped plain byte, bare terminator value
        chk = BYTE_W'(8'h00 + 8'hFF + FRAME_CHAR_RESET * 3 + 8'h55 + FRAME_TERM_RESET * 2
            + FRAME_CHAR_RESET);
        send_item(chk, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(FRAME_CHAR_RESET, 1'b0);
        send_item(FRAME_CHAR_RESET, 1'b0);
        send_item(FRAME_CHAR_RESET, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(FRAME_TERM_RESET, 1'b0);
        send_item(FRAME_CHAR_RESET, 1'b0);
        send_item(FRAME_TERM_RESET, 1'b0);
        // checksum mismatch
        send_item(8'hA5, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(FRAME_CHAR_RESET, 1'b0);
        send_item(FRAME_TERM_RESET, 1'b0);
        // resync in the header, then resync with an escape open
        send_item(8'h77, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(FRAME_CHAR_RESET, 1'b0);
        send_item(8'h00, 1'b1);
        // empty packet straight after, so a stale escape would show
        send_item(FRAME_CHAR_RESET + FRAME_TERM_RESET, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(FRAME_CHAR_RESET, 1'b0);
        send_item(FRAME_TERM_RESET, 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        @(negedge clk);
        hold_requests++;
        @(posedge clk);
        repeat (3) send_packet($urandom_range(24, 40), 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_oversize();
        send_packet(PAYLOAD_LIMIT + 18, 1'b1, 1'b0);
        send_packet(3, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_frame_settings();
        logic [BYTE_W-1:0] char_set[$];
        logic [BYTE_W-1:0] term_set[$];
        char_set = '{8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h00};
        term_set = '{8'hFF, 8'h00, 8'h5A, 8'hFF, 8'h00};
        char_set.push_back(BYTE_W'($urandom_range(0, 255)));
        term_set.push_back(BYTE_W'($urandom_range(0, 255)));
        foreach (char_set[k])
        begin
            write_cfg(CFG_FRAME_CHAR, char_set[k]);
            write_cfg(CFG_FRAME_TERM, term_set[k]);
            write_cfg(k[0] ? CFG_SPARE_LO : CFG_SPARE_HI, BYTE_W'($urandom_range(0, 255)));
            repeat (3)
                send_packet($urandom_range(0, 12), $urandom_range(0, 3) != 0,
                            $urandom_range(0, 5) == 0);
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        int unsigned first;
        int unsigned pick;
        first = item_count;
        write_cfg(CFG_FRAME_CHAR, FRAME_CHAR_RESET);
        write_cfg(CFG_FRAME_TERM, FRAME_TERM_RESET);
        while (item_count - first < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                wait_idle();
                write_cfg(CFG_FRAME_CHAR, BYTE_W'($urandom_range(0, 255)));
                write_cfg(CFG_FRAME_TERM,
                          ($urandom_range(0, 5) == 0) ? esc_char
                                                      : BYTE_W'($urandom_range(0, 255)));
            end
            else if (pick < 78)
                send_packet(($urandom_range(0, 7) == 0) ? $urandom_range(17, 80)
                                                        : $urandom_range(0, 16),
                            $urandom_range(0, 3) != 0, 1'b0);
            else if (pick < 90)
                send_packet($urandom_range(0, 16), $urandom_range(0, 1) != 0, 1'b1);
            else
                repeat ($urandom_range(1, 8))
                    send_item(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        resync    = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_FRAME_CHAR;
        cfg_data  = '0;
        esc_char  = FRAME_CHAR_RESET;
        term_char = FRAME_TERM_RESET;
        clear_rx_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_oversize();
        test_frame_settings();
        test_random_traffic();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule : escaped_packet_deframer_tb

// ===== filelist.f =====
hdl/epd_pkg.sv
hdl/epd_core.sv
hdl/escaped_packet_deframer.sv
tb/sv/escaped_packet_deframer_tb.sv
